// ===== hdl/assert_macros.svh =====
// Assertion macros for the port-level checker file of the pin event capture queues.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on each rising edge, off while reset is asserted
`define PECQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on each rising edge, reset included
`define PECQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== hdl/pecq_pkg.sv =====
// Package for the pin event capture queues: word types, codes and defaults.
// Used by every module of the block but pecq_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pecq_pkg;

    // Default sizing
    localparam int SLOT_COUNT_DEF = 16;
    localparam int RING_DEPTH_DEF = 8;

    // Fixed field widths
    localparam int PIN_W  = 8;
    localparam int TIME_W = 32;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_EDGE     = 2'd1,
        OP_READ     = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    // Read status codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_OK      = 2'd1,
        EV_INVALID = 2'd2
    } ev_status_t;

    // Input word
    typedef struct packed {
        op_t                opcode;
        logic [PIN_W-1:0]   pin_id;
        logic               pin_present;
        logic               pin_level;
        logic [TIME_W-1:0]  timestamp;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic               success;
        ev_status_t         event_status;
        logic               event_level;
        logic [TIME_W-1:0]  event_time;
    } out_word_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_FETCH,
        S_EMIT
    } fsm_state_t;

    // Kind of result to stage
    typedef enum logic [2:0] {
        RK_REG_FAIL,
        RK_REG_OK,
        RK_INVALID,
        RK_EMPTY,
        RK_EVENT
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       find;
        logic       claim;
        logic       append;
        logic       pop;
        logic       stage;
        res_kind_t  kind;
        logic       emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t   op;
        logic  present;
        logic  found;
        logic  has_free;
        logic  fill_zero;
        logic  out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/pin_event_capture_queues_top.sv =====
// A result passes the states FIND, DECIDE and EMIT after its word is accepted, with FETCH
// before EMIT for a popped event; edge words skip EMIT, and EMIT waits on a held output;
// the controller handles one word at a time (compare, pointer RAM read, update).
// A waiting result sits in the output register while the next word is taken.
// Reset (async, active low) frees all slots and empties the output; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module pin_event_capture_queues_top
    import pecq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_word_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_word_t      result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pecq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    pecq_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

// ===== hdl/pecq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module pecq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/pecq_ctrl.sv =====
// Controller of the pin event capture queues: sequences one item at a time.
// Depends on pecq_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pecq_ctrl
    import pecq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = RK_REG_FAIL;
        item_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FIND;
                end
            end

            // slot chosen, pointers fetched
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                unique case (status.op)
                    OP_REGISTER:
                    begin
                        cmd.stage  = 1'b1;
                        state_next = S_EMIT;
                        if (!status.present)
                        begin
                            cmd.kind = RK_REG_FAIL;
                        end
                        else if (status.found)
                        begin
                            cmd.kind = RK_REG_OK;
                        end
                        else if (status.has_free)
                        begin
                            cmd.claim = 1'b1;
                            cmd.kind  = RK_REG_OK;
                        end
                        else
                        begin
                            cmd.kind = RK_REG_FAIL;
                        end
                    end

                    OP_EDGE:
                    begin
                        cmd.append = status.found && status.present;
                        state_next = S_IDLE;
                    end

                    OP_READ:
                    begin
                        if (!status.found)
                        begin
                            cmd.stage  = 1'b1;
                            cmd.kind   = RK_INVALID;
                            state_next = S_EMIT;
                        end
                        else if (status.fill_zero)
                        begin
                            cmd.stage  = 1'b1;
                            cmd.kind   = RK_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_FETCH;
                        end
                    end

                    OP_UNUSED:
                    begin
                        state_next = S_IDLE;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // ring word now on the RAM output
            S_FETCH:
            begin
                cmd.stage  = 1'b1;
                cmd.kind   = RK_EVENT;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pecq_dp.sv =====
// Datapath of the pin event capture queues: slot table, pointer and ring RAMs,
// result staging and output register. Depends on pecq_pkg and pecq_ram.
`timescale 1ns / 1ps
`default_nettype none

module pecq_dp
    import pecq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  item,
    input  wire dp_cmd_t   cmd,
    output dp_status_t     status,
    output out_word_t      result,
    output logic           result_valid,
    input  wire logic      result_stall
);

    localparam int SW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW      = $clog2(RING_DEPTH);
    localparam int FW      = $clog2(RING_DEPTH + 1);
    localparam int PTR_W   = PW + FW;
    localparam int RING_W  = 1 + TIME_W;
    localparam int SUM_W   = ((PW > FW) ? PW : FW) + 1;
    localparam int PTR_DEPTH  = 1 << SW;
    localparam int RING_DEPTH_MEM = 1 << (SW + PW);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(RING_DEPTH);
    localparam logic [FW-1:0]    DEPTH_FILL = FW'(RING_DEPTH);
    localparam logic [PW-1:0]    LAST_POS   = PW'(RING_DEPTH - 1);

    // Item and slot table
    in_word_t              item_reg;
    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] match_reg;
    logic [SLOT_COUNT-1:0] free_reg;
    logic [PIN_W-1:0]      pin_reg [SLOT_COUNT];
    logic [SW-1:0]         slot_reg;
    logic                  found_reg;
    logic                  has_free_reg;

    // Result staging and output
    out_word_t             res_reg;
    out_word_t             res_next;
    out_word_t             result_reg;
    logic                  result_valid_reg;

    // Search results
    logic [SW-1:0]         match_idx;
    logic                  match_any;
    logic [SW-1:0]         free_idx;
    logic                  free_any;
    logic [SW-1:0]         pick_idx;

    // Pointer arithmetic
    logic                  ptr_we;
    logic [PTR_W-1:0]      ptr_wdata;
    logic [PTR_W-1:0]      ptr_rdata;
    logic [PW-1:0]         tail;
    logic [FW-1:0]         fill;
    logic [PW-1:0]         tail_next;
    logic [SUM_W-1:0]      head_sum;
    logic [PW-1:0]         head;
    logic                  fill_full;

    // Ring store
    logic [RING_W-1:0]     ring_wdata;
    logic [RING_W-1:0]     ring_rdata;

    // First matching slot and first free slot
    always_comb
    begin
        match_idx = '0;
        match_any = 1'b0;
        free_idx  = '0;
        free_any  = 1'b0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            if (match_reg[s])
            begin
                match_idx = SW'(s);
                match_any = 1'b1;
            end
            if (free_reg[s])
            begin
                free_idx = SW'(s);
                free_any = 1'b1;
            end
        end
        pick_idx = match_any ? match_idx : free_idx;
    end

    // Item capture and parallel pin compare
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                match_reg[s] <= used_reg[s] && (pin_reg[s] == item.pin_id);
            end
            free_reg <= ~used_reg;
        end
        if (cmd.find)
        begin
            slot_reg     <= pick_idx;
            found_reg    <= match_any;
            has_free_reg <= free_any;
        end
    end

    // Slot ownership
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.claim)
        begin
            used_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim)
        begin
            pin_reg[slot_reg] <= item_reg.pin_id;
        end
    end

    // Ring pointers: head is derived from tail and fill
    assign tail      = ptr_rdata[PTR_W-1:FW];
    assign fill      = ptr_rdata[FW-1:0];
    assign tail_next = (tail == LAST_POS) ? '0 : tail + PW'(1);
    assign head_sum  = SUM_W'(tail) + SUM_W'(fill);
    assign head      = (head_sum >= DEPTH_SUM) ? PW'(head_sum - DEPTH_SUM) : PW'(head_sum);
    assign fill_full = (fill == DEPTH_FILL);

    // Pointer update: claim clears, append advances head (and tail on a full ring), pop advances tail
    always_comb
    begin
        ptr_we    = cmd.claim || cmd.append || cmd.pop;
        ptr_wdata = '0;
        if (cmd.append)
        begin
            ptr_wdata = fill_full ? {tail_next, fill} : {tail, fill + FW'(1)};
        end
        else if (cmd.pop)
        begin
            ptr_wdata = {tail_next, fill - FW'(1)};
        end
    end

    pecq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (PTR_DEPTH)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (slot_reg),
        .wdata (ptr_wdata),
        .re    (cmd.find),
        .raddr (pick_idx),
        .rdata (ptr_rdata)
    );

    assign ring_wdata = {item_reg.pin_level, item_reg.timestamp};

    pecq_ram #(
        .WIDTH (RING_W),
        .DEPTH (RING_DEPTH_MEM)
    ) u_ring_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr ({slot_reg, head}),
        .wdata (ring_wdata),
        .re    (cmd.pop),
        .raddr ({slot_reg, tail}),
        .rdata (ring_rdata)
    );

    // Result staging
    always_comb
    begin
        res_next = res_reg;
        if (cmd.stage)
        begin
            res_next = '0;
            case (cmd.kind)
                RK_REG_OK:
                begin
                    res_next.success = 1'b1;
                end
                RK_INVALID:
                begin
                    res_next.event_status = EV_INVALID;
                end
                RK_EMPTY:
                begin
                    res_next.success = 1'b1;
                end
                RK_EVENT:
                begin
                    res_next.success      = 1'b1;
                    res_next.event_status = EV_OK;
                    res_next.event_level  = ring_rdata[TIME_W];
                    res_next.event_time   = ring_rdata[TIME_W-1:0];
                end
                default:
                begin
                    res_next.success = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Status to controller
    assign status.op        = item_reg.opcode;
    assign status.present   = item_reg.pin_present;
    assign status.found     = found_reg;
    assign status.has_free  = has_free_reg;
    assign status.fill_zero = (fill == '0);
    assign status.out_free  = !result_valid_reg || !result_stall;

endmodule

`default_nettype wire

// ===== hdl/pecq_checker.sv =====
// Port-level checks for the pin event capture queues, bound to the top level.
// Depends on pecq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pecq_assertions
    import pecq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      item_valid,
    input wire logic      item_stall,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_word_t result
);

    logic item_take;
    logic ev_fields_zero;

    assign item_take      = item_valid && !item_stall;
    assign ev_fields_zero = (result.event_time == '0) && !result.event_level;

    // No result word during reset
    `PECQ_ASSERT_ALWAYS(a_reset_empty, (!rst_n |-> !result_valid), "result valid in reset")

    // One word at a time: busy right after an accept
    `PECQ_ASSERT(a_busy_after_accept, (item_take |=> item_stall), "accept without stall after")

    // Stalled result holds
    `PECQ_ASSERT(a_result_hold, (result_valid && result_stall |=> result_valid && $stable(result)), "stalled result changed")

    // Invalid id never reports success
    `PECQ_ASSERT(a_invalid_fails, (result_valid && result.event_status == EV_INVALID |-> !result.success), "invalid id with success")

    // Event fields are zero unless an event was popped
    `PECQ_ASSERT(a_no_event_zero, (result_valid && result.event_status != EV_OK |-> ev_fields_zero), "event fields set")

endmodule

bind pin_event_capture_queues_top pecq_assertions u_pecq_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

// ===== bench/pecq_checker.sv =====
// Checker for the pin event capture queues: watches both channels, keeps its own
// copy of the slot table and rings, and compares every result word with its forecast.
// Depends on pecq_pkg for the word types and codes.
`timescale 1ns / 1ps

module pecq_checker
    import pecq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire logic      item_stall,
    input  wire in_word_t  item,
    input  wire logic      result_valid,
    input  wire logic      result_stall,
    input  wire out_word_t result,
    output int             errors,
    output int             outstanding,
    output int             replies_seen
);

    // Shadow slot table and rings
    bit                 slot_used [SLOT_COUNT];
    logic [PIN_W-1:0]   slot_pin  [SLOT_COUNT];
    logic               ring_lvl  [SLOT_COUNT][RING_DEPTH];
    logic [TIME_W-1:0]  ring_ts   [SLOT_COUNT][RING_DEPTH];
    int                 wr_ptr    [SLOT_COUNT];
    int                 rd_ptr    [SLOT_COUNT];
    int                 fill      [SLOT_COUNT];

    out_word_t replies_due [$];
    int        miss_count;
    int        seen_count;

    assign errors       = miss_count;
    assign replies_seen = seen_count;

    // Slot holding a pin, or -1
    function automatic int find_slot(input logic [PIN_W-1:0] pin);
        for (int k = 0; k < SLOT_COUNT; k++)
            if (slot_used[k] && slot_pin[k] == pin)
                return k;
        return -1;
    endfunction

    // Applies one word to the shadow table; returns 1 when it yields a reply
    function automatic bit step_pin_table(input in_word_t w, output out_word_t r);
        int s;
        s = find_slot(w.pin_id);
        r = '0;
        case (w.opcode)
            OP_REGISTER:
            begin
                if (w.pin_present)
                begin
                    // claim the first free slot, ring cleared
                    for (int k = 0; k < SLOT_COUNT && s < 0; k++)
                        if (!slot_used[k])
                        begin
                            slot_used[k] = 1'b1;
                            slot_pin[k]  = w.pin_id;
                            wr_ptr[k]    = 0;
                            rd_ptr[k]    = 0;
                            fill[k]      = 0;
                            s            = k;
                        end
                    r.success = (s >= 0);
                end
                r.event_status = EV_NONE;
                return 1'b1;
            end
            OP_EDGE:
            begin
                if (s >= 0 && w.pin_present)
                begin
                    // full ring: drop the oldest entry first
                    if (fill[s] >= RING_DEPTH)
                    begin
                        rd_ptr[s] = (rd_ptr[s] + 1) % RING_DEPTH;
                        fill[s]   = fill[s] - 1;
                    end
                    ring_lvl[s][wr_ptr[s]] = w.pin_level;
                    ring_ts[s][wr_ptr[s]]  = w.timestamp;
                    wr_ptr[s] = (wr_ptr[s] + 1) % RING_DEPTH;
                    fill[s]   = fill[s] + 1;
                end
                return 1'b0;
            end
            OP_READ:
            begin
                if (s < 0)
                begin
                    r.event_status = EV_INVALID;
                    return 1'b1;
                end
                r.success = 1'b1;
                if (fill[s] == 0)
                begin
                    r.event_status = EV_NONE;
                    return 1'b1;
                end
                r.event_status = EV_OK;
                r.event_level  = ring_lvl[s][rd_ptr[s]];
                r.event_time   = ring_ts[s][rd_ptr[s]];
                rd_ptr[s] = (rd_ptr[s] + 1) % RING_DEPTH;
                fill[s]   = fill[s] - 1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Channel monitor: result side first, then the accepted input word
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_used[k] = 1'b0;
                wr_ptr[k]    = 0;
                rd_ptr[k]    = 0;
                fill[k]      = 0;
            end
            replies_due.delete();
            miss_count  = 0;
            seen_count  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got = result;
                seen_count++;
                if (replies_due.size() == 0)
                begin
                    $error("result word with nothing expected: %h", got);
                    miss_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0d, got %0d", want.success, got.success);
                        miss_count++;
                    end
                    if (got.event_status !== want.event_status)
                    begin
                        $error("event_status: expected %0d, got %0d",
                               want.event_status, got.event_status);
                        miss_count++;
                    end
                    if (got.event_level !== want.event_level)
                    begin
                        $error("event_level: expected %0d, got %0d",
                               want.event_level, got.event_level);
                        miss_count++;
                    end
                    if (got.event_time !== want.event_time)
                    begin
                        $error("event_time: expected %h, got %h",
                               want.event_time, got.event_time);
                        miss_count++;
                    end
                end
            end
            if (item_valid && !item_stall)
                if (step_pin_table(item, want))
                    replies_due.push_back(want);
            outstanding <= replies_due.size();
        end
    end

endmodule

// ===== bench/tb_pin_event_capture_queues_top.sv =====
// Bench top for the pin event capture queues: clock, reset, input words and the verdict.
// Directed words first, then random traffic mostly over a small pool of pins; pecq_checker judges.
// Depends on pecq_pkg, pecq_checker and pin_event_capture_queues_top.
`timescale 1ns / 1ps

module tb_pin_event_capture_queues_top
    import pecq_pkg::*;
();

    localparam int RANDOM_WORDS = 550;

    logic      clk          = 1'b0;
    logic      rst_n;
    logic      item_valid   = 1'b0;
    in_word_t  item         = '0;
    logic      result_stall = 1'b0;
    logic      item_stall;
    logic      result_valid;
    out_word_t result;

    int errors;
    int outstanding;
    int replies_seen;
    int words_sent = 0;
    bit calm = 1'b0;

    logic [PIN_W-1:0] known_pins [$];

    pin_event_capture_queues_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pecq_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding),
        .replies_seen (replies_seen)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure, off during the calm stretch
    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(99) < 24);

    // Run limit
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic in_word_t mk(input op_t op, input logic [PIN_W-1:0] pin,
                                    input logic present, input logic level,
                                    input logic [TIME_W-1:0] ts);
        in_word_t w;
        w.opcode      = op;
        w.pin_id      = pin;
        w.pin_present = present;
        w.pin_level   = level;
        w.timestamp   = ts;
        return w;
    endfunction

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input in_word_t w);
        bit listed;
        while (!calm && $urandom_range(99) < 24)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        words_sent++;
        // remember pins put up for registration
        if (w.opcode == OP_REGISTER && w.pin_present && known_pins.size() < 24)
        begin
            listed = 1'b0;
            foreach (known_pins[k])
                if (known_pins[k] == w.pin_id)
                    listed = 1'b1;
            if (!listed)
                known_pins.push_back(w.pin_id);
        end
    endtask

    // Drop valid and wait until every expected reply is back, plus settling time
    task automatic drain_replies();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin : stimulus
        in_word_t         w;
        int               pick;
        logic [PIN_W-1:0] pin;
        op_t              op;

        // reset edge at time zero so the asynchronous reset takes hold at once
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unknown pin, absent pin, re-register, empty ring, extremes
        send_word(mk(OP_READ,     8'd0,   1'b1, 1'b0, 32'd0));
        send_word(mk(OP_REGISTER, 8'd5,   1'b0, 1'b0, 32'd0));
        send_word(mk(OP_EDGE,     8'd5,   1'b1, 1'b1, 32'h1234_5678));
        send_word(mk(OP_REGISTER, 8'd0,   1'b1, 1'b0, 32'd0));
        send_word(mk(OP_REGISTER, 8'd255, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_word(mk(OP_REGISTER, 8'd0,   1'b1, 1'b0, 32'd0));
        send_word(mk(OP_READ,     8'd0,   1'b1, 1'b0, 32'd0));
        send_word(mk(OP_EDGE,     8'd0,   1'b1, 1'b1, 32'hFFFF_FFFF));
        send_word(mk(OP_EDGE,     8'd0,   1'b0, 1'b0, 32'hDEAD_BEEF));
        send_word(mk(OP_UNUSED,   8'd0,   1'b1, 1'b1, 32'hFFFF_FFFF));
        send_word(mk(OP_READ,     8'd0,   1'b1, 1'b0, 32'd0));
        // overfill one ring so the oldest entry is dropped
        for (int k = 0; k < RING_DEPTH_DEF + 1; k++)
            send_word(mk(OP_EDGE, 8'd255, 1'b1, k[0], k));
        send_word(mk(OP_READ, 8'd255, 1'b1, 1'b0, 32'd0));
        send_word(mk(OP_READ, 8'd255, 1'b1, 1'b0, 32'd0));

        // Random traffic, edge-heavy and read-heavy phases in turn
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= 200 && i < 300);
            if (i == 400)
                drain_replies();
            pick = $urandom_range(99);
            if (((i / 100) % 2) == 0)
                op = (pick < 15) ? OP_REGISTER : (pick < 70) ? OP_EDGE :
                     (pick < 95) ? OP_READ : OP_UNUSED;
            else
                op = (pick < 10) ? OP_REGISTER : (pick < 45) ? OP_EDGE :
                     (pick < 95) ? OP_READ : OP_UNUSED;
            if (known_pins.size() > 0 && $urandom_range(99) < 75)
                pin = known_pins[$urandom_range(known_pins.size() - 1)];
            else
                pin = PIN_W'($urandom_range(255));
            w = mk(op, pin, ($urandom_range(99) < 90), 1'($urandom_range(1)), $urandom);
            send_word(w);
        end
        calm = 1'b0;
        drain_replies();

        $display("Run covered %0d input words and %0d checked replies: registration up to a",
                 words_sent, replies_seen);
        $display("full table, ring overflow, empty and unknown reads, and ignored words.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pecq_pkg.sv
hdl/pecq_ram.sv
hdl/pecq_ctrl.sv
hdl/pecq_dp.sv
hdl/pin_event_capture_queues_top.sv
hdl/pecq_checker.sv
bench/pecq_checker.sv
bench/tb_pin_event_capture_queues_top.sv
